// ===== sv/dbd_pkg.sv =====
// dbd_pkg: shared constants, register codes and helper functions for the
// detection box decoder. Used by detection_box_decode_core and dbd_checker.
`default_nettype none

package dbd_pkg;

   // hard limits of the decoder
   localparam int MAX_BOXES   = 16384;
   localparam int MAX_CLASSES = 252;

   localparam logic [16:0] MAX_BOXES_W   = 17'(MAX_BOXES);
   localparam logic [7:0]  MAX_CLASSES_W = 8'(MAX_CLASSES);

   // number of box geometry elements ahead of the scores
   localparam logic [7:0] GEOM_ELEMENTS = 8'd4;

   // control register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_SCALE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_COUNT     = 3'd6;

   // register reset values
   localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd16384;
   localparam logic [15:0] RST_INVERSE_SCALE   = 16'd4096;
   localparam logic [9:0]  RST_OFFSET_X        = 10'd0;
   localparam logic [9:0]  RST_OFFSET_Y        = 10'd0;
   localparam logic [11:0] RST_IMAGE_WIDTH     = 12'd640;
   localparam logic [11:0] RST_IMAGE_HEIGHT    = 12'd640;
   localparam logic [7:0]  RST_CLASS_COUNT     = 8'd80;

   // rounding constant for the Q.17 to Q.4 reduction
   localparam logic [34:0] ROUND_HALF = 35'd4096;

   // corner numerator in Q.5, already clamped at zero
   typedef logic [17:0] numer_type;
   // scaled corner in Q.4 before clamping to the image
   typedef logic [21:0] scaled_type;

   function automatic logic [7:0] effective_classes(input logic [7:0] count);
      logic [7:0] n;
      n = count;
      if (n == 8'd0) begin
         n = 8'd1;
      end
      if (n > MAX_CLASSES_W) begin
         n = MAX_CLASSES_W;
      end
      return n;
   endfunction

   // 2*centre -/+ size - 32*offset, non-positive values give zero
   function automatic numer_type corner_numer(input logic [15:0] centre,
                                              input logic [15:0] size,
                                              input logic        upper,
                                              input logic [9:0]  offset);
      logic signed [19:0] num;
      logic signed [19:0] sz;
      sz  = $signed({4'b0, size});
      num = $signed({3'b0, centre, 1'b0}) - $signed({5'b0, offset, 5'b0});
      num = upper ? (num + sz) : (num - sz);
      if (num <= 20'sd0) begin
         return '0;
      end
      return num[17:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/detection_box_decode_core.sv =====
// Detection box decoder: a detection passes the stage 1, stage 2 and output
// registers after the transfer of its last score; throughput one element per cycle
// unless rsp_stall holds the pipeline (scaling multipliers are fully pipelined).
// Stages: accept/argmax and corner numerators, scaling multiply and round,
// clamp and box check into the output register.
// Reset (synchronous, active high) restores register defaults, clears the
// running best score and class and empties the pipeline; box geometry is not reset.
`default_nettype none

module detection_box_decode_core
   import dbd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [15:0]            req_element_value,
   input  wire logic [7:0]             req_element_index,
   input  wire logic [13:0]            req_box_index,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [15:0]            rsp_left,
   output      logic [15:0]            rsp_top,
   output      logic [15:0]            rsp_right,
   output      logic [15:0]            rsp_bottom,
   output      logic [15:0]            rsp_confidence,
   output      logic [7:0]             rsp_class_index,
   output      logic [13:0]            rsp_anchor_id,

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_wdata
);

   // control registers
   logic [15:0] score_threshold_ff;
   logic [15:0] inverse_scale_ff;
   logic [9:0]  offset_x_ff;
   logic [9:0]  offset_y_ff;
   logic [11:0] image_width_ff;
   logic [11:0] image_height_ff;
   logic [7:0]  class_count_ff;

   // box state
   logic [15:0] geom_ff [4];
   logic [15:0] best_score_ff, best_score_in;
   logic [7:0]  lead_class_ff, lead_class_in;

   // stage 1: numerators
   logic        s1_valid_ff, s1_valid_in;
   numer_type   s1_x1_ff, s1_x2_ff, s1_y1_ff, s1_y2_ff;
   logic [15:0] s1_conf_ff;
   logic [7:0]  s1_class_ff;
   logic [13:0] s1_anchor_ff;

   // stage 2: scaled corners
   logic        s2_valid_ff, s2_valid_in;
   scaled_type  s2_x1_ff, s2_x2_ff, s2_y1_ff, s2_y2_ff;
   logic [15:0] s2_conf_ff;
   logic [7:0]  s2_class_ff;
   logic [13:0] s2_anchor_ff;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_left_ff, out_top_ff, out_right_ff, out_bottom_ff;
   logic [15:0] out_conf_ff;
   logic [7:0]  out_class_ff;
   logic [13:0] out_anchor_ff;

   logic        req_xfer;
   logic        anchor_ok;
   logic        is_geom;
   logic        is_score;
   logic [7:0]  classes;
   logic [7:0]  cls;
   logic        take_new;
   logic        fire;
   logic        s1_adv;
   logic        s2_adv;

   scaled_type  sc_x1, sc_x2, sc_y1, sc_y2;
   logic [15:0] lim_x, lim_y;
   logic [15:0] cl_x1, cl_x2, cl_y1, cl_y2;
   logic        keep;

   // pipeline flow: a stage moves when the next one is empty or moving
   assign s2_adv    = ~out_valid_ff | ~rsp_stall;
   assign s1_adv    = ~s2_valid_ff | s2_adv;
   assign req_stall = s1_valid_ff & ~s1_adv;
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      classes   = effective_classes(class_count_ff);
      cls       = req_element_index - GEOM_ELEMENTS;
      anchor_ok = {3'b0, req_box_index} < MAX_BOXES_W;
      is_geom   = req_xfer & anchor_ok & (req_element_index < GEOM_ELEMENTS);
      is_score  = req_xfer & anchor_ok & (req_element_index >= GEOM_ELEMENTS)
                  & (cls < classes);
      // first score reloads, later ones need strict greater-than
      take_new  = (cls == 8'd0) | (req_element_value > best_score_ff);
      best_score_in = best_score_ff;
      lead_class_in = lead_class_ff;
      if (is_score && take_new) begin
         best_score_in = req_element_value;
         lead_class_in = cls;
      end
      fire = is_score & (cls == classes - 8'd1)
             & (best_score_in >= score_threshold_ff);
      s1_valid_in = fire | (s1_valid_ff & ~s1_adv);
      s2_valid_in = s1_adv ? s1_valid_ff : s2_valid_ff;
   end

   // round half up from Q.17 to Q.4
   function automatic scaled_type scale(input numer_type num, input logic [15:0] inv);
      logic [34:0] full;
      full = 35'(num) * 35'(inv) + ROUND_HALF;
      return full[34:13];
   endfunction

   always_comb begin
      sc_x1 = s2_x1_ff;
      sc_x2 = s2_x2_ff;
      sc_y1 = s2_y1_ff;
      sc_y2 = s2_y2_ff;
      lim_x = {image_width_ff, 4'b0};
      lim_y = {image_height_ff, 4'b0};
      cl_x1 = (sc_x1 > {6'b0, lim_x}) ? lim_x : sc_x1[15:0];
      cl_x2 = (sc_x2 > {6'b0, lim_x}) ? lim_x : sc_x2[15:0];
      cl_y1 = (sc_y1 > {6'b0, lim_y}) ? lim_y : sc_y1[15:0];
      cl_y2 = (sc_y2 > {6'b0, lim_y}) ? lim_y : sc_y2[15:0];
      keep  = (cl_x2 > cl_x1) & (cl_y2 > cl_y1);
      out_valid_in = s2_adv ? (s2_valid_ff & keep) : out_valid_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         score_threshold_ff <= RST_SCORE_THRESHOLD;
         inverse_scale_ff   <= RST_INVERSE_SCALE;
         offset_x_ff        <= RST_OFFSET_X;
         offset_y_ff        <= RST_OFFSET_Y;
         image_width_ff     <= RST_IMAGE_WIDTH;
         image_height_ff    <= RST_IMAGE_HEIGHT;
         class_count_ff     <= RST_CLASS_COUNT;
         best_score_ff      <= '0;
         lead_class_ff      <= '0;
         s1_valid_ff        <= 1'b0;
         s2_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCORE_THRESHOLD: score_threshold_ff <= csr_wdata;
               CSR_INVERSE_SCALE:   inverse_scale_ff   <= csr_wdata;
               CSR_OFFSET_X:        offset_x_ff        <= csr_wdata[9:0];
               CSR_OFFSET_Y:        offset_y_ff        <= csr_wdata[9:0];
               CSR_IMAGE_WIDTH:     image_width_ff     <= csr_wdata[11:0];
               CSR_IMAGE_HEIGHT:    image_height_ff    <= csr_wdata[11:0];
               CSR_CLASS_COUNT:     class_count_ff     <= csr_wdata[7:0];
               default: ;
            endcase
         end
         best_score_ff <= best_score_in;
         lead_class_ff <= lead_class_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (is_geom) begin
         geom_ff[req_element_index[1:0]] <= req_element_value;
      end
      if (fire) begin
         s1_x1_ff     <= corner_numer(geom_ff[0], geom_ff[2], 1'b0, offset_x_ff);
         s1_x2_ff     <= corner_numer(geom_ff[0], geom_ff[2], 1'b1, offset_x_ff);
         s1_y1_ff     <= corner_numer(geom_ff[1], geom_ff[3], 1'b0, offset_y_ff);
         s1_y2_ff     <= corner_numer(geom_ff[1], geom_ff[3], 1'b1, offset_y_ff);
         s1_conf_ff   <= best_score_in;
         s1_class_ff  <= lead_class_in;
         s1_anchor_ff <= req_box_index;
      end
      if (s1_adv && s1_valid_ff) begin
         s2_x1_ff     <= scale(s1_x1_ff, inverse_scale_ff);
         s2_x2_ff     <= scale(s1_x2_ff, inverse_scale_ff);
         s2_y1_ff     <= scale(s1_y1_ff, inverse_scale_ff);
         s2_y2_ff     <= scale(s1_y2_ff, inverse_scale_ff);
         s2_conf_ff   <= s1_conf_ff;
         s2_class_ff  <= s1_class_ff;
         s2_anchor_ff <= s1_anchor_ff;
      end
      if (s2_adv && s2_valid_ff) begin
         out_left_ff   <= cl_x1;
         out_top_ff    <= cl_y1;
         out_right_ff  <= cl_x2;
         out_bottom_ff <= cl_y2;
         out_conf_ff   <= s2_conf_ff;
         out_class_ff  <= s2_class_ff;
         out_anchor_ff <= s2_anchor_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left        = out_left_ff;
   assign rsp_top         = out_top_ff;
   assign rsp_right       = out_right_ff;
   assign rsp_bottom      = out_bottom_ff;
   assign rsp_confidence  = out_conf_ff;
   assign rsp_class_index = out_class_ff;
   assign rsp_anchor_id   = out_anchor_ff;

endmodule

`default_nettype wire

// ===== sv/dbd_checker.sv =====
// dbd_checker: port-level assertions for detection_box_decode_core,
// attached by bind. Depends on dbd_pkg.
`default_nettype none

module dbd_checker
   import dbd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_left,
   input wire logic [15:0] rsp_top,
   input wire logic [15:0] rsp_right,
   input wire logic [15:0] rsp_bottom,
   input wire logic [7:0]  rsp_class_index
);

   // pipeline empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left) && $stable(rsp_right))
      else $error("stalled result changed");

   // only non-empty boxes leave the block
   a_box_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right > rsp_left) && (rsp_bottom > rsp_top))
      else $error("empty box emitted");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class_index < MAX_CLASSES_W)
      else $error("class index out of range");

endmodule

bind detection_box_decode_core dbd_checker u_dbd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_left        (rsp_left),
   .rsp_top         (rsp_top),
   .rsp_right       (rsp_right),
   .rsp_bottom      (rsp_bottom),
   .rsp_class_index (rsp_class_index)
);

`default_nettype wire
